// ===== src/sdlp_pkg.sv =====
package sdlp_pkg;

   // one received byte with its line-status flag
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_error;
   } req_type;

   // one parsed line result
   typedef struct packed {
      logic signed [20:0] value;
      logic [1:0]         status;
   } rsp_type;

   // classified byte as held in the queue
   typedef struct packed {
      logic       rx_err;
      logic       is_cr;
      logic       is_n;
      logic       is_plus;
      logic       is_minus;
      logic       is_digit;
      logic [3:0] digit;
   } tok_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FORMAT  = 2'd1;
   localparam logic [1:0] ST_LONG    = 2'd2;
   localparam logic [1:0] ST_RECEIVE = 2'd3;

   // characters
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // magnitude limits
   localparam logic [19:0] MAG_MAX   = 20'hFFFFF;
   localparam logic [19:0] MAG_LIMIT = 20'd104857;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

endpackage

// ===== src/sdlp_front.sv =====
module sdlp_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  sdlp_pkg::req_type   req_data,
   input  sdlp_pkg::qstat_type q_stat,
   output logic               push,
   output sdlp_pkg::tok_type   tok
);
   import sdlp_pkg::*;

   logic good;

   assign good      = ~req_data.rx_error;
   assign req_stall = q_stat.full;
   assign push      = req_valid & ~q_stat.full;

   always_comb begin
      tok          = '0;
      tok.rx_err   = req_data.rx_error;
      tok.is_cr    = good && (req_data.rx_byte == CHAR_CR);
      tok.is_n     = (req_data.rx_byte == CHAR_N);
      tok.is_plus  = (req_data.rx_byte == CHAR_PLUS);
      tok.is_minus = (req_data.rx_byte == CHAR_MINUS);
      tok.is_digit = (req_data.rx_byte >= CHAR_ZERO) && (req_data.rx_byte <= CHAR_NINE);
      // low nibble of '0'..'9' is the digit value
      tok.digit    = req_data.rx_byte[3:0];
   end

endmodule

// ===== src/sdlp_queue.sv =====
module sdlp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sdlp_pkg::tok_type   wdata,
   input  logic               pop,
   output sdlp_pkg::tok_type   rdata,
   output sdlp_pkg::qstat_type q_stat
);
   import sdlp_pkg::*;

   tok_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign rdata        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/sdlp_back.sv =====
module sdlp_back #(
   parameter int LINE_CHARS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  sdlp_pkg::qstat_type q_stat,
   input  sdlp_pkg::tok_type   tok,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sdlp_pkg::rsp_type   rsp_data
);
   import sdlp_pkg::*;

   localparam logic [3:0] LineCharsC = 4'(LINE_CHARS);

   logic [3:0]  count_ff, count_in;
   logic [19:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [1:0]  err_ff, err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        slot_free;
   logic [23:0] mag_next;
   logic [1:0]  end_status;
   logic [20:0] mag_wide;

   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   // a line end needs the output slot, other words never wait
   assign pop       = ~q_stat.empty & (~tok.is_cr | slot_free);

   assign mag_next = 24'({mag_ff, 3'b000}) + 24'({mag_ff, 1'b0}) + 24'(tok.digit);
   assign mag_wide = {1'b0, mag_ff};

   always_comb begin
      end_status = err_ff;
      if (err_ff == ST_OK && count_ff != LineCharsC) begin
         end_status = ST_FORMAT;
      end
   end

   always_comb begin
      count_in     = count_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         if (tok.rx_err) begin
            if (err_ff == ST_OK) begin
               err_in = ST_RECEIVE;
            end
         end else if (tok.is_cr) begin
            rsp_valid_in       = 1'b1;
            rsp_data_in.status = end_status;
            rsp_data_in.value  = '0;
            if (end_status == ST_OK) begin
               rsp_data_in.value = neg_ff ? -mag_wide : mag_wide;
            end
            count_in = '0;
            mag_in   = '0;
            neg_in   = 1'b0;
            err_in   = ST_OK;
         end else if (err_ff == ST_OK) begin
            if (count_ff >= LineCharsC) begin
               err_in = ST_LONG;
            end else begin
               count_in = count_ff + 1'b1;
               if (count_ff == 4'd0) begin
                  if (!tok.is_n) begin
                     err_in = ST_FORMAT;
                  end
               end else if (count_ff == 4'd1) begin
                  if (tok.is_minus) begin
                     neg_in = 1'b1;
                  end else if (!tok.is_plus) begin
                     err_in = ST_FORMAT;
                  end
               end else if (!tok.is_digit) begin
                  err_in = ST_FORMAT;
               end else if (mag_ff > MAG_LIMIT || mag_next > 24'(MAG_MAX)) begin
                  mag_in = MAG_MAX;
               end else begin
                  mag_in = mag_next[19:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/signed_decimal_line_parser_core.sv =====
// signed decimal line parser
//
// req channel: one received serial word per item (character plus the
// receiver's line-status error flag). lines read 'N', a sign, then
// LINE_CHARS-2 decimal digits, and end with a carriage return.
// rsp channel: one word per carriage return, signed value and status
// (ok, bad format or length, line too long, receive error). value is
// zero whenever status is not ok. other characters give no word.
// words flagged with a receive error never end a line.
// throughput: one req word per cycle while req_stall is low. a
// classified word sits in a four-entry queue, the back end takes one a
// cycle (a line end only with a free rsp slot) and updates the line
// state; a line end shows on rsp in the cycle after it leaves the queue.
// a rsp stall holds line ends, and words behind them, in the queue;
// req_stall rises once full; reset clears queue, line state, rsp_valid.
module signed_decimal_line_parser_core #(
   parameter int LINE_CHARS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sdlp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sdlp_pkg::rsp_type rsp_data
);
   import sdlp_pkg::*;

   // front to queue
   logic      push;
   tok_type   tok_wr;
   // queue to back
   tok_type   tok_rd;
   logic      pop;
   qstat_type q_stat;

   // classify incoming characters
   sdlp_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .tok       (tok_wr)
   );

   // short queue decoupling acceptance from the line state update
   sdlp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (tok_wr),
      .pop    (pop),
      .rdata  (tok_rd),
      .q_stat (q_stat)
   );

   // line state, accumulate and the result register
   sdlp_back #(
      .LINE_CHARS (LINE_CHARS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .tok       (tok_rd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // failed lines carry a zero value
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.value == '0))
      else $error("nonzero value on failed line");

   // queue cannot be full and empty at once
   a_q_sane : assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty together");

   // an accepted word is held in the queue the next cycle
   a_push_held : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_stat.empty)
      else $error("accepted word lost");

   // nothing is drained from an empty queue
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !pop)
      else $error("pop from empty queue");
`endif

endmodule
